FILE: hw/rtl/rtcm3_pkg.sv
// Shared types and constants for the RTCM3 station position extractor.
package rtcm3_pkg;

  localparam logic [7:0]  PREAMBLE     = 8'hD3;
  localparam logic [11:0] MSG_1005     = 12'd1005;
  localparam logic [11:0] MSG_1006     = 12'd1006;
  // payload_length + 6 >= 22
  localparam logic [9:0]  MIN_PAYLOAD  = 10'd16;
  // last byte index = payload_length + FRAME_TAIL
  localparam logic [10:0] FRAME_TAIL   = 11'd5;

  localparam logic [10:0] POS_LEN_HI   = 11'd1;
  localparam logic [10:0] POS_LEN_LO   = 11'd2;
  localparam logic [10:0] POS_TYPE_HI  = 11'd3;
  localparam logic [10:0] POS_TYPE_LO  = 11'd4;

  localparam int FIELD_BYTES = 22;
  localparam int CAP_IDX_W   = 6;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [8*FIELD_BYTES-1:0] frame_vec_t;

  typedef struct packed {
    logic [7:0]           data;
    logic [CAP_IDX_W-1:0] idx;
    logic                 cap_en;
    logic                 report;
    logic                 is_1006;
  } qent_t;

endpackage

FILE: hw/rtl/rtcm3_if.sv
// Channel interfaces: byte input, station result output, configuration write.
interface rtcm3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rtcm3_out_if;
  logic               valid;
  logic               ready;
  logic [11:0]        station_id;
  logic [5:0]         itrf_year;
  logic               is_type_1006;
  logic signed [37:0] ecef_x;
  logic signed [37:0] ecef_y;
  logic signed [37:0] ecef_z;
  modport source (output valid, output station_id, output itrf_year, output is_type_1006,
                  output ecef_x, output ecef_y, output ecef_z, input ready);
  modport sink (input valid, input station_id, input itrf_year, input is_type_1006,
                input ecef_x, input ecef_y, input ecef_z, output ready);
endinterface

interface rtcm3_cfg_if;
  logic valid;
  logic ready;
  logic once_only;
  modport source (output valid, output once_only, input ready);
  modport sink (input valid, input once_only, output ready);
endinterface

FILE: hw/rtl/rtcm3_station_position_extract.sv
// Top level of the RTCM3 1005/1006 station position extractor.
//
//   channel   dir  request                   handshake
//   in_ch     in   one stream byte           valid/ready
//   out_ch    out  one station result        valid/ready
//   cfg_ch    in   once_only register write  valid/ready (ready tied high)
//
// One byte per cycle sustained; in_ch.ready drops only when the two-entry
// queue is full. A result is registered once the last byte leaves the queue.
// A result waiting on out_ch stalls the back end only at the next report;
// other bytes keep draining. Synchronous reset; no clearing pass.
module rtcm3_station_position_extract #(
  parameter int CAPTURE_BYTES = 22
) (
  input  logic          clk,
  input  logic          rst_n,
  rtcm3_in_if.sink      in_ch,
  rtcm3_out_if.source   out_ch,
  rtcm3_cfg_if.sink     cfg_ch
);

  logic             q_push;
  rtcm3_pkg::qent_t q_entry;
  logic             q_ready;
  logic             q_valid;
  rtcm3_pkg::qent_t q_head;
  logic             q_pop;

  rtcm3_front #(.CAPTURE_BYTES(CAPTURE_BYTES)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg_ch  (cfg_ch),
    .q_push  (q_push),
    .q_entry (q_entry),
    .q_ready (q_ready)
  );

  rtcm3_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .ready      (q_ready),
    .valid      (q_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  rtcm3_back #(.CAPTURE_BYTES(CAPTURE_BYTES)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_ready)
    else $error("queue push while full");

  a_result_from_report: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(q_pop && q_head.report))
    else $error("result without a report entry");

  a_report_held: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_head.report && out_ch.valid && !out_ch.ready) |-> !q_pop)
    else $error("report popped over a pending result");
`endif

endmodule

FILE: hw/rtl/rtcm3_front.sv
// Frame tracker: finds preambles, decodes header, tags bytes for the back end.
module rtcm3_front #(
  parameter int CAPTURE_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  rtcm3_in_if.sink            in_ch,
  rtcm3_cfg_if.sink           cfg_ch,
  output logic                q_push,
  output rtcm3_pkg::qent_t    q_entry,
  input  logic                q_ready
);

  localparam logic PH_HUNT  = 1'b0;
  localparam logic PH_FRAME = 1'b1;

  logic        phase_r, phase_nxt;
  logic [10:0] pos_r, pos_nxt;
  logic [9:0]  pl_r, pl_nxt;
  logic [11:0] mt_r, mt_nxt;
  logic        found_r, found_nxt;
  logic        once_only_r;
  logic        in_fire;
  logic        last_byte;
  logic        type_ok;
  logic        report;

  assign in_ch.ready  = q_ready;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && q_ready;

  assign last_byte = (pos_r == ({1'b0, pl_r} + rtcm3_pkg::FRAME_TAIL));
  assign type_ok   = (mt_r == rtcm3_pkg::MSG_1005) || (mt_r == rtcm3_pkg::MSG_1006);
  assign report    = last_byte && type_ok && (pl_r >= rtcm3_pkg::MIN_PAYLOAD)
                     && !(once_only_r && found_r);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    pl_nxt    = pl_r;
    mt_nxt    = mt_r;
    found_nxt = found_r;
    q_push    = 1'b0;
    q_entry   = '{data: in_ch.rx_byte,
                  idx: pos_r[rtcm3_pkg::CAP_IDX_W-1:0],
                  cap_en: (pos_r < 11'(CAPTURE_BYTES)),
                  report: report,
                  is_1006: (mt_r == rtcm3_pkg::MSG_1006)};
    if (in_fire) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_ch.rx_byte == rtcm3_pkg::PREAMBLE) begin
            q_push         = 1'b1;
            q_entry.idx    = '0;
            q_entry.cap_en = 1'b1;
            q_entry.report = 1'b0;
            pos_nxt        = 11'd1;
            pl_nxt         = '0;
            mt_nxt         = '0;
            phase_nxt      = PH_FRAME;
          end
        end
        PH_FRAME: begin
          q_push = 1'b1;
          unique case (pos_r)
            rtcm3_pkg::POS_LEN_HI:  pl_nxt = {in_ch.rx_byte[1:0], 8'h00};
            rtcm3_pkg::POS_LEN_LO:  pl_nxt = {pl_r[9:8], in_ch.rx_byte};
            rtcm3_pkg::POS_TYPE_HI: mt_nxt = {in_ch.rx_byte, 4'h0};
            rtcm3_pkg::POS_TYPE_LO: mt_nxt = {mt_r[11:4], in_ch.rx_byte[7:4]};
            default: ;
          endcase
          if (last_byte) begin
            phase_nxt = PH_HUNT;
            pos_nxt   = '0;
            if (report) begin
              found_nxt = 1'b1;
            end
          end else begin
            pos_nxt = pos_r + 11'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      pos_r       <= '0;
      pl_r        <= '0;
      mt_r        <= '0;
      found_r     <= 1'b0;
      once_only_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      pl_r    <= pl_nxt;
      mt_r    <= mt_nxt;
      found_r <= found_nxt;
      if (cfg_ch.valid) begin
        once_only_r <= cfg_ch.once_only;
      end
    end
  end

endmodule

FILE: hw/rtl/rtcm3_queue.sv
// Two-entry queue of tagged bytes between frame tracker and field assembler.
module rtcm3_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rtcm3_pkg::qent_t push_entry,
  output logic             ready,
  output logic             valid,
  output rtcm3_pkg::qent_t head,
  input  logic             pop
);

  localparam int PTR_W = $clog2(rtcm3_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(rtcm3_pkg::QUEUE_DEPTH + 1);

  rtcm3_pkg::qent_t     mem_r [rtcm3_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  assign ready = (cnt_r != CNT_W'(rtcm3_pkg::QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/rtcm3_back.sv
// Field assembler: stores frame bytes and registers station results.
module rtcm3_back #(
  parameter int CAPTURE_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  rtcm3_pkg::qent_t q_head,
  output logic             q_pop,
  rtcm3_out_if.source      out_ch
);

  localparam int IDX_W = $clog2(CAPTURE_BYTES);

  logic [7:0]            cap_r [CAPTURE_BYTES];
  rtcm3_pkg::frame_vec_t frame_vec;
  logic                  out_valid_r, out_valid_nxt;
  logic [11:0]           station_id_r;
  logic [5:0]            itrf_year_r;
  logic                  is_1006_r;
  logic signed [37:0]    ecef_x_r;
  logic signed [37:0]    ecef_y_r;
  logic signed [37:0]    ecef_z_r;
  logic                  load;

  assign q_pop = q_valid && !(q_head.report && out_valid_r && !out_ch.ready);
  assign load  = q_pop && q_head.report;

  // Stored bytes with the byte being popped merged in
  always_comb begin
    logic [7:0] cur;
    for (int i = 0; i < rtcm3_pkg::FIELD_BYTES; i++) begin
      cur = cap_r[i];
      if (q_head.cap_en && (q_head.idx == rtcm3_pkg::CAP_IDX_W'(i))) begin
        cur = q_head.data;
      end
      frame_vec[8*(rtcm3_pkg::FIELD_BYTES-1-i) +: 8] = cur;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.cap_en) begin
      cap_r[q_head.idx[IDX_W-1:0]] <= q_head.data;
    end
    if (load) begin
      station_id_r <= frame_vec[139:128];
      itrf_year_r  <= frame_vec[127:122];
      is_1006_r    <= q_head.is_1006;
      ecef_x_r     <= $signed(frame_vec[117:80]);
      ecef_y_r     <= $signed(frame_vec[77:40]);
      ecef_z_r     <= $signed(frame_vec[37:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.station_id   = station_id_r;
  assign out_ch.itrf_year    = itrf_year_r;
  assign out_ch.is_type_1006 = is_1006_r;
  assign out_ch.ecef_x       = ecef_x_r;
  assign out_ch.ecef_y       = ecef_y_r;
  assign out_ch.ecef_z       = ecef_z_r;

endmodule
